// ----- sv/wdig_pkg.sv -----
package wdig_pkg;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_FIELD_BITS = 2'd0;
  localparam logic [1:0] REG_FIELD_POLY = 2'd1;
  localparam logic [1:0] REG_NUM_COEFFS = 2'd2;

  // Address and data widths of the configuration port.
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  // Register widths.
  localparam int unsigned FIELD_BITS_W = 5;
  localparam int unsigned FIELD_POLY_W = 16;
  localparam int unsigned NUM_COEFFS_W = 3;

  // Register reset values.
  localparam logic [FIELD_BITS_W-1:0] FIELD_BITS_RST = 5'd8;
  localparam logic [FIELD_POLY_W-1:0] FIELD_POLY_RST = 16'd29;
  localparam logic [NUM_COEFFS_W-1:0] NUM_COEFFS_RST = 3'd2;

  // Payload widths.
  localparam int unsigned SET_INDEX_W = 64;
  localparam int unsigned POINT_W     = 16;
  localparam int unsigned BIT_INDEX_W = 32;

endpackage

// ----- sv/wdig_cfg.sv -----
module wdig_cfg #(
  parameter int unsigned MAX_FIELD_BITS = 16,
  parameter int unsigned MAX_COEFFS     = 4,
  localparam int unsigned LW = $clog2(MAX_FIELD_BITS + 1),
  localparam int unsigned NW = $clog2(MAX_COEFFS + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wdig_pkg::ADDR_W-1:0]       paddr,
  input  logic [wdig_pkg::DATA_W-1:0]       pwdata,
  output logic [wdig_pkg::DATA_W-1:0]       prdata,
  output logic [LW-1:0]                     field_len,
  output logic [MAX_FIELD_BITS-1:0]         field_mask,
  output logic [MAX_FIELD_BITS-1:0]         field_top,
  output logic [MAX_FIELD_BITS-1:0]         field_poly,
  output logic [NW-1:0]                     coeff_cnt
);

  logic [wdig_pkg::FIELD_BITS_W-1:0] field_bits_r;
  logic [wdig_pkg::FIELD_POLY_W-1:0] field_poly_r;
  logic [wdig_pkg::NUM_COEFFS_W-1:0] num_coeffs_r;
  logic                              wr_en;
  logic [1:0]                        reg_idx;
  logic [MAX_FIELD_BITS+wdig_pkg::FIELD_POLY_W-1:0] poly_ext;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Register writes complete in the access cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_bits_r <= wdig_pkg::FIELD_BITS_RST;
      field_poly_r <= wdig_pkg::FIELD_POLY_RST;
      num_coeffs_r <= wdig_pkg::NUM_COEFFS_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        wdig_pkg::REG_FIELD_BITS: field_bits_r <= pwdata[wdig_pkg::FIELD_BITS_W-1:0];
        wdig_pkg::REG_FIELD_POLY: field_poly_r <= pwdata[wdig_pkg::FIELD_POLY_W-1:0];
        wdig_pkg::REG_NUM_COEFFS: num_coeffs_r <= pwdata[wdig_pkg::NUM_COEFFS_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (reg_idx)
      wdig_pkg::REG_FIELD_BITS:
        prdata = {{(wdig_pkg::DATA_W-wdig_pkg::FIELD_BITS_W){1'b0}}, field_bits_r};
      wdig_pkg::REG_FIELD_POLY:
        prdata = {{(wdig_pkg::DATA_W-wdig_pkg::FIELD_POLY_W){1'b0}}, field_poly_r};
      wdig_pkg::REG_NUM_COEFFS:
        prdata = {{(wdig_pkg::DATA_W-wdig_pkg::NUM_COEFFS_W){1'b0}}, num_coeffs_r};
      default:
        prdata = '0;
    endcase
  end

  // Field width clamped to the range the datapath supports.
  always_comb begin
    if (field_bits_r == '0) begin
      field_len = LW'(1);
    end else if ({1'b0, field_bits_r} > 6'(MAX_FIELD_BITS)) begin
      field_len = LW'(MAX_FIELD_BITS);
    end else begin
      field_len = LW'(field_bits_r);
    end
  end

  // Element mask, its top bit, and the reduction terms inside the field.
  always_comb begin
    for (int i = 0; i < MAX_FIELD_BITS; i++) begin
      field_mask[i] = (LW'(i) < field_len);
    end
    field_top  = field_mask ^ (field_mask >> 1);
    poly_ext   = {{MAX_FIELD_BITS{1'b0}}, field_poly_r};
    field_poly = poly_ext[MAX_FIELD_BITS-1:0] & field_mask;
  end

  // Coefficient count clamped to the number of cells.
  always_comb begin
    if ({1'b0, num_coeffs_r} > 4'(MAX_COEFFS)) begin
      coeff_cnt = NW'(MAX_COEFFS);
    end else begin
      coeff_cnt = NW'(num_coeffs_r);
    end
  end

endmodule

// ----- sv/wdig_cell.sv -----
module wdig_cell #(
  parameter int unsigned MAX_FIELD_BITS = 16,
  localparam int unsigned LW = $clog2(MAX_FIELD_BITS + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [LW-1:0]                      field_len,
  input  logic [MAX_FIELD_BITS-1:0]          field_mask,
  input  logic [MAX_FIELD_BITS-1:0]          field_top,
  input  logic [MAX_FIELD_BITS-1:0]          field_poly,
  input  logic                               active,
  input  logic                               up_valid,
  output logic                               up_ready,
  input  logic [wdig_pkg::SET_INDEX_W-1:0]   up_set,
  input  logic [MAX_FIELD_BITS-1:0]          up_point,
  input  logic [MAX_FIELD_BITS-1:0]          up_res,
  output logic                               dn_valid,
  input  logic                               dn_ready,
  output logic [wdig_pkg::SET_INDEX_W-1:0]   dn_set,
  output logic [MAX_FIELD_BITS-1:0]          dn_point,
  output logic [MAX_FIELD_BITS-1:0]          dn_res
);

  logic                             valid_r, valid_nxt;
  logic [wdig_pkg::SET_INDEX_W-1:0] set_r, set_nxt;
  logic [MAX_FIELD_BITS-1:0]        point_r;
  logic [MAX_FIELD_BITS-1:0]        res_r, res_nxt;
  logic [MAX_FIELD_BITS-1:0]        prod;
  logic [MAX_FIELD_BITS-1:0]        acc;
  logic [MAX_FIELD_BITS-1:0]        mul_a;
  logic [MAX_FIELD_BITS-1:0]        coeff;
  logic                             load;

  // The stage takes a beat when empty or when its contents move on.
  assign up_ready = !valid_r || dn_ready;
  assign load     = up_valid && up_ready;

  // Carry-less multiply of the running result by the point, reduced per shift.
  always_comb begin
    acc   = '0;
    mul_a = up_res & field_mask;
    for (int k = 0; k < MAX_FIELD_BITS; k++) begin
      if (up_point[k]) begin
        acc = acc ^ mul_a;
      end
      if (|(mul_a & field_top)) begin
        mul_a = ((mul_a << 1) & field_mask) ^ field_poly;
      end else begin
        mul_a = (mul_a << 1) & field_mask;
      end
    end
    prod = acc & field_mask;
  end

  // One Horner step; the coefficient is the low field of the remaining set bits.
  assign coeff   = up_set[MAX_FIELD_BITS-1:0] & field_mask;
  assign res_nxt = active ? (prod ^ coeff) : up_res;
  assign set_nxt = up_set >> field_len;

  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      set_r   <= set_nxt;
      point_r <= up_point;
      res_r   <= res_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_set   = set_r;
  assign dn_point = point_r;
  assign dn_res   = res_r;

endmodule

// ----- sv/weak_design_index_generator_unit.sv -----
// Seed bit index generator for a polynomial weak design over GF(2^L). Each beat on the
// input carries a set number and an evaluation point; one beat on the output returns
// the point in the low L bits with the polynomial value above it, cut to 32 bits. The
// datapath is a row of MAX_COEFFS cells, one Horner step (a GF multiply and an xor)
// per cell, followed by an output register. The first cell loads at the edge that
// accepts a beat, and the beat then moves through each cell's register and then the
// output register; a new beat is accepted every cycle while the output side
// keeps taking results. Cells past the configured coefficient count pass the value
// through unchanged. The user must write registers over the APB port only while no
// beat is in flight; the block itself does not enforce this.
module weak_design_index_generator_unit #(
  parameter int unsigned MAX_FIELD_BITS = 16,
  parameter int unsigned MAX_COEFFS     = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wdig_pkg::ADDR_W-1:0]       paddr,
  input  logic [wdig_pkg::DATA_W-1:0]       pwdata,
  output logic [wdig_pkg::DATA_W-1:0]       prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [wdig_pkg::SET_INDEX_W-1:0]  in_set_index,
  input  logic [wdig_pkg::POINT_W-1:0]      in_point,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [wdig_pkg::BIT_INDEX_W-1:0]  out_bit_index
);

  localparam int unsigned LW = $clog2(MAX_FIELD_BITS + 1);
  localparam int unsigned NW = $clog2(MAX_COEFFS + 1);
  localparam int unsigned WW = 2 * MAX_FIELD_BITS + wdig_pkg::BIT_INDEX_W;
  localparam int unsigned PW = MAX_FIELD_BITS + wdig_pkg::POINT_W;

  logic [LW-1:0]             field_len;
  logic [MAX_FIELD_BITS-1:0] field_mask;
  logic [MAX_FIELD_BITS-1:0] field_top;
  logic [MAX_FIELD_BITS-1:0] field_poly;
  logic [NW-1:0]             coeff_cnt;

  logic                             ch_valid [MAX_COEFFS+1];
  logic                             ch_ready [MAX_COEFFS+1];
  logic [wdig_pkg::SET_INDEX_W-1:0] ch_set   [MAX_COEFFS+1];
  logic [MAX_FIELD_BITS-1:0]        ch_point [MAX_COEFFS+1];
  logic [MAX_FIELD_BITS-1:0]        ch_res   [MAX_COEFFS+1];

  logic [PW-1:0]                    point_ext;
  logic [WW-1:0]                    idx_wide;
  logic                             out_valid_r, out_valid_nxt;
  logic [wdig_pkg::BIT_INDEX_W-1:0] bit_index_r;

  assign pready = 1'b1;

  wdig_cfg #(
    .MAX_FIELD_BITS(MAX_FIELD_BITS),
    .MAX_COEFFS    (MAX_COEFFS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .field_len (field_len),
    .field_mask(field_mask),
    .field_top (field_top),
    .field_poly(field_poly),
    .coeff_cnt (coeff_cnt)
  );

  // Input beat enters the first cell with the point masked to the field.
  assign point_ext   = {{MAX_FIELD_BITS{1'b0}}, in_point};
  assign ch_valid[0] = in_valid;
  assign ch_set[0]   = in_set_index;
  assign ch_point[0] = point_ext[MAX_FIELD_BITS-1:0] & field_mask;
  assign ch_res[0]   = '0;
  assign in_stall    = !ch_ready[0];

  // Row of Horner cells.
  for (genvar k = 0; k < MAX_COEFFS; k++) begin : g_cell
    wdig_cell #(
      .MAX_FIELD_BITS(MAX_FIELD_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .field_len (field_len),
      .field_mask(field_mask),
      .field_top (field_top),
      .field_poly(field_poly),
      .active    (NW'(k) < coeff_cnt),
      .up_valid  (ch_valid[k]),
      .up_ready  (ch_ready[k]),
      .up_set    (ch_set[k]),
      .up_point  (ch_point[k]),
      .up_res    (ch_res[k]),
      .dn_valid  (ch_valid[k+1]),
      .dn_ready  (ch_ready[k+1]),
      .dn_set    (ch_set[k+1]),
      .dn_point  (ch_point[k+1]),
      .dn_res    (ch_res[k+1])
    );
  end

  // Output register: result placed above the point.
  assign ch_ready[MAX_COEFFS] = !out_valid_r || !out_stall;
  assign idx_wide = ({{(MAX_FIELD_BITS+wdig_pkg::BIT_INDEX_W){1'b0}}, ch_res[MAX_COEFFS]}
                     << field_len)
                  | {{(MAX_FIELD_BITS+wdig_pkg::BIT_INDEX_W){1'b0}}, ch_point[MAX_COEFFS]};
  assign out_valid_nxt = ch_ready[MAX_COEFFS] ? ch_valid[MAX_COEFFS] : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ch_ready[MAX_COEFFS] && ch_valid[MAX_COEFFS]) begin
      bit_index_r <= idx_wide[wdig_pkg::BIT_INDEX_W-1:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_bit_index = bit_index_r;

endmodule

// ----- bench/tb_weak_design_index_generator_unit.sv -----
module tb_weak_design_index_generator_unit;

  localparam int unsigned MAX_FIELD_BITS = 16;
  localparam int unsigned MAX_COEFFS     = 4;
  localparam int unsigned NUM_PHASES     = 10;
  localparam int unsigned PHASE_BEATS    = 130;
  localparam int unsigned MAX_REPORTS    = 10;

  // Keeps its own copy of the registers and the bit indexes still owed by the block.
  class bit_index_board;
    logic [wdig_pkg::FIELD_BITS_W-1:0] field_bits;
    logic [wdig_pkg::FIELD_POLY_W-1:0] field_poly;
    logic [wdig_pkg::NUM_COEFFS_W-1:0] num_coeffs;
    logic [wdig_pkg::BIT_INDEX_W-1:0]  expected_bit_index[$];
    int unsigned                       mismatches;

    function new();
      field_bits = wdig_pkg::FIELD_BITS_RST;
      field_poly = wdig_pkg::FIELD_POLY_RST;
      num_coeffs = wdig_pkg::NUM_COEFFS_RST;
      mismatches = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [wdig_pkg::DATA_W-1:0] value);
      case (idx)
        wdig_pkg::REG_FIELD_BITS: field_bits = value[wdig_pkg::FIELD_BITS_W-1:0];
        wdig_pkg::REG_FIELD_POLY: field_poly = value[wdig_pkg::FIELD_POLY_W-1:0];
        wdig_pkg::REG_NUM_COEFFS: num_coeffs = value[wdig_pkg::NUM_COEFFS_W-1:0];
        default: ;
      endcase
    endfunction

    // Carry-less product of x and y, reduced by x^width + poly.
    function logic [15:0] gf_mul_reduce(logic [15:0] x, logic [15:0] y,
                                        logic [15:0] poly, int unsigned width);
      logic [15:0] mask;
      logic [15:0] top;
      logic [15:0] acc;
      mask = 16'((32'd1 << width) - 32'd1);
      top  = 16'(32'd1 << (width - 1));
      acc  = '0;
      x    = x & mask;
      y    = y & mask;
      for (int k = 0; k < width; k++) begin
        logic carry;
        if (y[k]) acc = acc ^ x;
        carry = |(x & top);
        x = (x << 1) & mask;
        if (carry) x = x ^ poly;
      end
      return acc & mask;
    endfunction

    // Horner evaluation of the set's polynomial at the point, placed above the point.
    function logic [wdig_pkg::BIT_INDEX_W-1:0] predict_bit_index(
        logic [wdig_pkg::SET_INDEX_W-1:0] set_index, logic [wdig_pkg::POINT_W-1:0] point);
      int unsigned width;
      int unsigned n;
      int unsigned pos;
      logic [15:0] mask;
      logic [15:0] poly;
      logic [15:0] a;
      logic [15:0] res;
      logic [15:0] coeff;
      width = 32'(field_bits);
      if (width < 1) width = 1;
      if (width > MAX_FIELD_BITS) width = MAX_FIELD_BITS;
      n = 32'(num_coeffs);
      if (n > MAX_COEFFS) n = MAX_COEFFS;
      mask = 16'((32'd1 << width) - 32'd1);
      poly = field_poly & mask;
      a    = point & mask;
      res  = '0;
      for (int k = 0; k < n; k++) begin
        pos   = k * width;
        coeff = (pos < 64) ? (16'(set_index >> pos) & mask) : 16'd0;
        res   = gf_mul_reduce(res, a, poly, width) ^ coeff;
      end
      return 32'(({16'd0, res} << width) | {16'd0, a});
    endfunction

    function void note_request(logic [wdig_pkg::SET_INDEX_W-1:0] set_index,
                               logic [wdig_pkg::POINT_W-1:0] point);
      expected_bit_index = {expected_bit_index, predict_bit_index(set_index, point)};
    endfunction

    function void check_bit_index(logic [wdig_pkg::BIT_INDEX_W-1:0] actual);
      logic [wdig_pkg::BIT_INDEX_W-1:0] want;
      if (expected_bit_index.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("bit_index beat %h arrived with nothing expected", actual);
      end else begin
        want = expected_bit_index.pop_front();
        if (want !== actual) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("bit_index mismatch: expected %h, got %h", want, actual);
        end
      end
    endfunction

    function int unsigned owed();
      return expected_bit_index.size();
    endfunction
  endclass

  logic                             clk;
  logic                             rst_n;
  logic                             psel;
  logic                             penable;
  logic                             pwrite;
  logic [wdig_pkg::ADDR_W-1:0]      paddr;
  logic [wdig_pkg::DATA_W-1:0]      pwdata;
  logic [wdig_pkg::DATA_W-1:0]      prdata;
  logic                             pready;
  logic                             in_valid;
  logic                             in_stall;
  logic [wdig_pkg::SET_INDEX_W-1:0] in_set_index;
  logic [wdig_pkg::POINT_W-1:0]     in_point;
  logic                             out_valid;
  logic                             out_stall;
  logic [wdig_pkg::BIT_INDEX_W-1:0] out_bit_index;

  bit_index_board board;
  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;

  // Directed requests at the reset setting: extremes, bit patterns, reduction carries.
  logic [wdig_pkg::SET_INDEX_W-1:0] dir_set[13] = '{
    64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
    64'h0000_0000_0000_0102, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
    64'h0000_0000_0000_FF01, 64'h8000_0000_0000_0000, 64'hFFFF_0000_FFFF_0000,
    64'h0123_4567_89AB_CDEF, 64'h1, 64'h100
  };
  logic [wdig_pkg::POINT_W-1:0] dir_point[13] = '{
    16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0002, 16'h5555, 16'hAAAA,
    16'h0080, 16'h0001, 16'h00FF, 16'h1234, 16'h0001, 16'h0003
  };

  // Settings per phase, with zero and oversized widths and coefficient counts.
  logic [wdig_pkg::FIELD_BITS_W-1:0] phase_bits[NUM_PHASES] = '{
    5'd0, 5'd1, 5'd16, 5'd17, 5'd31, 5'd5, 5'd12, 5'd16, 5'd3, 5'd8
  };
  logic [wdig_pkg::FIELD_POLY_W-1:0] phase_poly[NUM_PHASES] = '{
    16'h0001, 16'hFFFF, 16'h002B, 16'h1021, 16'hFFFF, 16'h0000, 16'h0053, 16'hFFFF,
    16'h0003, 16'd29
  };
  logic [wdig_pkg::NUM_COEFFS_W-1:0] phase_coeffs[NUM_PHASES] = '{
    3'd3, 3'd4, 3'd4, 3'd0, 3'd7, 3'd5, 3'd1, 3'd4, 3'd6, 3'd2
  };

  weak_design_index_generator_unit u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_set_index  (in_set_index),
    .in_point      (in_point),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_bit_index (out_bit_index)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Register write: setup cycle, then access cycle until pready.
  task automatic cfg_write(input logic [1:0] idx, input logic [wdig_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.write_reg(idx, value);
  endtask

  // One input beat, with a random gap ahead of it; the payload holds while stalled.
  task automatic send_request(input logic [wdig_pkg::SET_INDEX_W-1:0] set_index,
                              input logic [wdig_pkg::POINT_W-1:0] point);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_set_index <= set_index;
    in_point     <= point;
    do @(posedge clk); while (in_stall);
    board.note_request(set_index, point);
  endtask

  // Hold off the sender until every owed bit index has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.owed() != 0);
  endtask

  // Output side: check each accepted beat and stall at random.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) board.check_bit_index(out_bit_index);
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  initial begin
    #3_000_000;
    $display("tb_weak_design_index_generator_unit failed");
    $finish;
  end

  initial begin
    logic [wdig_pkg::SET_INDEX_W-1:0]  set_index;
    logic [wdig_pkg::POINT_W-1:0]      point;
    logic [wdig_pkg::FIELD_POLY_W-1:0] poly;
    int unsigned                       pick;
    board         = new();
    send_idle_pct = 23;
    recv_idle_pct = 52;
    rst_n        <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_valid     <= 1'b0;
    in_set_index <= '0;
    in_point     <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_set[i]) send_request(dir_set[i], dir_point[i]);
    drain_results();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 4) begin
        send_idle_pct = 23;
        recv_idle_pct = 52;
      end else if (ph < 7) begin
        send_idle_pct = 52;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      // Unused upper bits of the write data carry random junk.
      poly = (ph % 3 == 2) ? 16'($urandom) : phase_poly[ph];
      cfg_write(wdig_pkg::REG_FIELD_BITS, ($urandom & ~32'h1F) | 32'(phase_bits[ph]));
      cfg_write(wdig_pkg::REG_FIELD_POLY, ($urandom & ~32'hFFFF) | 32'(poly));
      cfg_write(wdig_pkg::REG_NUM_COEFFS, ($urandom & ~32'h7) | 32'(phase_coeffs[ph]));

      for (int i = 0; i < PHASE_BEATS; i++) begin
        if (i == PHASE_BEATS / 2) drain_results();
        set_index = {$urandom, $urandom};
        point     = 16'($urandom);
        pick      = $urandom_range(9);
        if (pick == 0) set_index = '0;
        else if (pick == 1) set_index = '1;
        else if (pick == 2) point = '0;
        else if (pick == 3) point = '1;
        send_request(set_index, point);
      end
      drain_results();
    end

    // Let any stray beat show up before the verdict.
    for (int w = 0; w < 20000 && board.owed() != 0; w++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.owed() != 0)
      $display("%0d bit_index beats never arrived", board.owed());
    if (board.mismatches == 0 && board.owed() == 0) begin
      $display("tb_weak_design_index_generator_unit passed");
    end else begin
      $display("tb_weak_design_index_generator_unit failed");
    end
    $finish;
  end

endmodule
